FILE: rtl/core/ichi_pkg.sv
// Shared types and constants for the Ichimoku line block: payload words,
// stored entry layouts, register codes and the sequencer states. No dependencies.
package ichi_pkg;

	localparam int PRICE_BITS = 32;
	localparam int TWICE_BITS = PRICE_BITS + 1;
	localparam int QUAD_BITS  = PRICE_BITS + 2;
	localparam int COUNT_BITS = 16;

	localparam int TENKAN_BITS = 8;
	localparam int KIJUN_BITS  = 7;
	localparam logic [TENKAN_BITS-1:0] TENKAN_DEFAULT = 8'd9;
	localparam logic [KIJUN_BITS-1:0]  KIJUN_DEFAULT  = 7'd26;

	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	// register select, taken from paddr[2]
	localparam logic REG_TENKAN = 1'b0;
	localparam logic REG_KIJUN  = 1'b1;

	typedef struct packed {
		logic [PRICE_BITS-1:0] high_price;
		logic [PRICE_BITS-1:0] low_price;
		logic [PRICE_BITS-1:0] close_price;
		logic                  first_bar;
	} ichi_in_t;

	typedef struct packed {
		logic [TWICE_BITS-1:0] tenkan_twice;
		logic                  tenkan_valid;
		logic [TWICE_BITS-1:0] kijun_twice;
		logic                  kijun_valid;
		logic [QUAD_BITS-1:0]  lead_mid_quad;
		logic                  lead_mid_valid;
		logic [TWICE_BITS-1:0] lead_wide_twice;
		logic                  lead_wide_valid;
		logic [PRICE_BITS-1:0] lagging_close;
		logic                  lagging_valid;
	} ichi_out_t;

	// one bar in the history memory
	typedef struct packed {
		logic [PRICE_BITS-1:0] high_price;
		logic [PRICE_BITS-1:0] low_price;
	} hist_word_t;

	// one bar's lines in the displacement memory
	typedef struct packed {
		logic                  ten_ok;
		logic [TWICE_BITS-1:0] ten_twice;
		logic                  kij_ok;
		logic [TWICE_BITS-1:0] kij_twice;
		logic                  wide_ok;
		logic [TWICE_BITS-1:0] wide_twice;
	} dly_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} ichi_state_t;

endpackage

FILE: rtl/core/ichi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ichi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/ichimoku_cloud_lines.sv
// Top level of the Ichimoku line block: APB registers, bar sequencer, history
// scan and displacement store. Depends on ichi_pkg and ichi_ram.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------
//  in      | to block  | in_valid/in_stall  | ichi_in_t: high, low, close, first
//  out     | from block| out_valid/out_stall| ichi_out_t: five lines and flags
//  apb     | to block  | psel/penable/pready| tenkan_period at 0, kijun at 4
//
// Scan: each bar reads L stored bars, L = max(tenkan, 2 * kijun) effective
// periods, so at most MAX_WINDOW. Set by the single read port of the
// history memory, one stored bar per cycle.
// Reset: no clearing pass; only memory entries written in the series are used.
// Stalls: a finished word waits in the output register; the next bar is taken
// meanwhile and holds in the finish step until the output register frees.
module ichimoku_cloud_lines #(
	parameter int MAX_WINDOW = 128,
	parameter int MAX_SHIFT  = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  ichi_pkg::ichi_in_t             in_word,

	output logic                           out_valid,
	input  logic                           out_stall,
	output ichi_pkg::ichi_out_t            out_word,

	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ichi_pkg::ADDR_BITS-1:0] paddr,
	input  logic [ichi_pkg::DATA_BITS-1:0] pwdata,
	output logic [ichi_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);

	// history index, period widths, kijun limit, displacement index
	localparam int HAW    = $clog2(MAX_WINDOW);
	localparam int TW     = $clog2(MAX_WINDOW + 1);
	localparam int KLIM   = (MAX_SHIFT < MAX_WINDOW / 2) ? MAX_SHIFT : MAX_WINDOW / 2;
	localparam int KW     = $clog2(KLIM + 1);
	localparam int DAW    = $clog2(MAX_SHIFT);
	localparam int HIST_W = $bits(ichi_pkg::hist_word_t);
	localparam int DLY_W  = $bits(ichi_pkg::dly_word_t);
	localparam int CB     = ichi_pkg::COUNT_BITS;
	localparam int PB     = ichi_pkg::PRICE_BITS;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [ichi_pkg::TENKAN_BITS-1:0] tenkan_q;
	logic [ichi_pkg::KIJUN_BITS-1:0]  kijun_q;
	logic                             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tenkan_q <= ichi_pkg::TENKAN_DEFAULT;
			kijun_q  <= ichi_pkg::KIJUN_DEFAULT;
		end else if (cfg_wr) begin
			case (paddr[2])
				ichi_pkg::REG_TENKAN: tenkan_q <= pwdata[ichi_pkg::TENKAN_BITS-1:0];
				ichi_pkg::REG_KIJUN:  kijun_q  <= pwdata[ichi_pkg::KIJUN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ichi_pkg::REG_TENKAN: prdata = ichi_pkg::DATA_BITS'(tenkan_q);
			ichi_pkg::REG_KIJUN:  prdata = ichi_pkg::DATA_BITS'(kijun_q);
			default:              prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Effective periods: zero means default, large values saturate
	// ---------------------------------------------------------------
	logic [15:0]    t_raw, k_raw;
	logic [TW-1:0]  t_eff, w_eff, scan_len;
	logic [KW-1:0]  k_eff;
	logic [HAW-1:0] t_last, k_last, w_last, scan_last;

	always_comb begin
		t_raw = (tenkan_q == '0) ? 16'(ichi_pkg::TENKAN_DEFAULT) : 16'(tenkan_q);
		if (t_raw > 16'(MAX_WINDOW)) begin
			t_raw = 16'(MAX_WINDOW);
		end
		k_raw = (kijun_q == '0) ? 16'(ichi_pkg::KIJUN_DEFAULT) : 16'(kijun_q);
		if (k_raw > 16'(KLIM)) begin
			k_raw = 16'(KLIM);
		end
		t_eff    = TW'(t_raw);
		k_eff    = KW'(k_raw);
		w_eff    = TW'(k_raw << 1);
		scan_len = (t_eff > w_eff) ? t_eff : w_eff;
		t_last    = HAW'(t_eff - TW'(1));
		k_last    = HAW'(k_raw - 16'd1);
		w_last    = HAW'(w_eff - TW'(1));
		scan_last = HAW'(scan_len - TW'(1));
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	ichi_pkg::ichi_state_t state_q, state_nx;
	logic accept, out_load;
	logic out_valid_q;

	assign in_stall  = (state_q != ichi_pkg::ST_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;

	logic [HAW-1:0] issue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ichi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		out_load = 1'b0;
		case (state_q)
			ichi_pkg::ST_IDLE: begin
				if (in_valid) state_nx = ichi_pkg::ST_SCAN;
			end
			ichi_pkg::ST_SCAN: begin
				if (issue_q == scan_last) state_nx = ichi_pkg::ST_DRAIN;
			end
			ichi_pkg::ST_DRAIN: begin
				state_nx = ichi_pkg::ST_FINISH;
			end
			ichi_pkg::ST_FINISH: begin
				// wait for the output register to free
				out_load = ~out_valid_q | ~out_stall;
				if (out_load) state_nx = ichi_pkg::ST_IDLE;
			end
			default: state_nx = ichi_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Bar count and slot pointers
	// ---------------------------------------------------------------
	logic [CB-1:0]  bar_count_q, cnt_base;
	logic [HAW-1:0] write_slot_q, rd_ptr_q;
	logic [DAW-1:0] delay_slot_q, rs;
	logic [15:0]    rs_sum;
	logic [PB-1:0]  close_q;

	assign cnt_base = in_word.first_bar ? '0 : bar_count_q;

	// displacement read slot: kijun bars back, modulo the store depth
	always_comb begin
		rs_sum = 16'(delay_slot_q) + 16'(MAX_SHIFT) - 16'(k_eff);
		if (rs_sum >= 16'(MAX_SHIFT)) begin
			rs_sum = rs_sum - 16'(MAX_SHIFT);
		end
		rs = DAW'(rs_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_count_q  <= '0;
			write_slot_q <= '0;
			delay_slot_q <= '0;
			rd_ptr_q     <= '0;
			issue_q      <= '0;
		end else begin
			if (accept) begin
				bar_count_q  <= (cnt_base == {CB{1'b1}}) ? cnt_base : cnt_base + 1'b1;
				write_slot_q <= (write_slot_q == HAW'(MAX_WINDOW - 1)) ? '0
				                : write_slot_q + 1'b1;
				rd_ptr_q     <= write_slot_q;  // newest bar first
				issue_q      <= '0;
			end else if (state_q == ichi_pkg::ST_SCAN) begin
				rd_ptr_q <= (rd_ptr_q == '0) ? HAW'(MAX_WINDOW - 1) : rd_ptr_q - 1'b1;
				if (issue_q != scan_last) issue_q <= issue_q + 1'b1;
			end
			if (out_load) begin
				delay_slot_q <= (delay_slot_q == DAW'(MAX_SHIFT - 1)) ? '0
				                : delay_slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) close_q <= in_word.close_price;
	end

	// ---------------------------------------------------------------
	// History memory: bar written on accept, scanned newest to oldest
	// ---------------------------------------------------------------
	logic [HIST_W-1:0]    hist_rdata;
	ichi_pkg::hist_word_t hist_wr, hist_rd;

	assign hist_wr.high_price = in_word.high_price;
	assign hist_wr.low_price  = in_word.low_price;
	assign hist_rd            = ichi_pkg::hist_word_t'(hist_rdata);

	ichi_ram #(.WIDTH(HIST_W), .DEPTH(MAX_WINDOW)) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (write_slot_q),
		.wdata (hist_wr),
		.re    (state_q == ichi_pkg::ST_SCAN),
		.raddr (rd_ptr_q),
		.rdata (hist_rdata)
	);

	logic           rd_valid_s1;
	logic [HAW-1:0] rd_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ichi_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q;
	end

	// running channel; snapshots at the end of each window
	logic [PB-1:0] hi_run_q, lo_run_q, hi_new, lo_new;
	logic [PB-1:0] t_hi_q, t_lo_q, k_hi_q, k_lo_q, w_hi_q, w_lo_q;
	logic          scan_first;

	assign scan_first = (rd_idx_s1 == '0);
	assign hi_new = (scan_first || hist_rd.high_price > hi_run_q) ? hist_rd.high_price : hi_run_q;
	assign lo_new = (scan_first || hist_rd.low_price < lo_run_q) ? hist_rd.low_price : lo_run_q;

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			hi_run_q <= hi_new;
			lo_run_q <= lo_new;
			if (rd_idx_s1 == t_last) begin
				t_hi_q <= hi_new;
				t_lo_q <= lo_new;
			end
			if (rd_idx_s1 == k_last) begin
				k_hi_q <= hi_new;
				k_lo_q <= lo_new;
			end
			if (rd_idx_s1 == w_last) begin
				w_hi_q <= hi_new;
				w_lo_q <= lo_new;
			end
		end
	end

	// ---------------------------------------------------------------
	// Displacement memory: read kijun bars back on accept, this bar's
	// lines written back in the finish step (read comes first, so a full
	// lap of the store still sees the old entry)
	// ---------------------------------------------------------------
	logic [DLY_W-1:0]    dly_rdata;
	ichi_pkg::dly_word_t dly_old, dly_new;

	assign dly_old = ichi_pkg::dly_word_t'(dly_rdata);

	ichi_ram #(.WIDTH(DLY_W), .DEPTH(MAX_SHIFT)) u_dly (
		.clk   (clk),
		.we    (out_load),
		.waddr (delay_slot_q),
		.wdata (dly_new),
		.re    (accept),
		.raddr (rs),
		.rdata (dly_rdata)
	);

	// ---------------------------------------------------------------
	// Finish: sums, flags, output word
	// ---------------------------------------------------------------
	logic tok, kok, wok, back, lmok, lwok;
	logic [ichi_pkg::TWICE_BITS-1:0] ten_sum, kij_sum, wide_sum;
	logic [ichi_pkg::QUAD_BITS-1:0]  lm_sum;
	ichi_pkg::ichi_out_t out_nx, out_word_q;

	always_comb begin
		tok  = bar_count_q >= CB'(t_eff);
		kok  = bar_count_q >= CB'(k_eff);
		wok  = bar_count_q >= CB'(w_eff);
		back = bar_count_q >  CB'(k_eff);

		ten_sum  = {1'b0, t_hi_q} + {1'b0, t_lo_q};
		kij_sum  = {1'b0, k_hi_q} + {1'b0, k_lo_q};
		wide_sum = {1'b0, w_hi_q} + {1'b0, w_lo_q};
		lm_sum   = {1'b0, dly_old.ten_twice} + {1'b0, dly_old.kij_twice};

		lmok = back & dly_old.ten_ok & dly_old.kij_ok;
		lwok = back & dly_old.wide_ok;

		out_nx.tenkan_twice    = tok  ? ten_sum  : '0;
		out_nx.tenkan_valid    = tok;
		out_nx.kijun_twice     = kok  ? kij_sum  : '0;
		out_nx.kijun_valid     = kok;
		out_nx.lead_mid_quad   = lmok ? lm_sum   : '0;
		out_nx.lead_mid_valid  = lmok;
		out_nx.lead_wide_twice = lwok ? dly_old.wide_twice : '0;
		out_nx.lead_wide_valid = lwok;
		out_nx.lagging_close   = close_q;
		out_nx.lagging_valid   = back;

		dly_new.ten_ok     = tok;
		dly_new.ten_twice  = out_nx.tenkan_twice;
		dly_new.kij_ok     = kok;
		dly_new.kij_twice  = out_nx.kijun_twice;
		dly_new.wide_ok    = wok;
		dly_new.wide_twice = wok ? wide_sum : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_word_q <= out_nx;
	end

	assign out_word = out_word_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_word_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ichi_pkg::ST_FINISH))
		else $error("output word raised outside the finish step");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ichi_pkg::ST_SCAN)
		else $error("accepted bar did not start a scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ichi_pkg::ST_SCAN |-> issue_q <= scan_last)
		else $error("scan ran past its window");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == ichi_pkg::ST_SCAN))
		else $error("history data tagged without a scan read");

endmodule

FILE: bench/cloud_check_pkg.sv
// Scoreboard for the Ichimoku line bench: a bit-true predictor of the five lines
// with its own history, displacement store and period registers. Depends on ichi_pkg.
package cloud_check_pkg;

	import ichi_pkg::*;

	localparam int HIST_DEPTH  = 128;
	localparam int SHIFT_DEPTH = 64;
	localparam int HIST_AW     = $clog2(HIST_DEPTH);
	localparam int SHIFT_AW    = $clog2(SHIFT_DEPTH);

	class cloud_line_predictor;
		logic [PRICE_BITS-1:0] high_hist [HIST_DEPTH];
		logic [PRICE_BITS-1:0] low_hist [HIST_DEPTH];
		logic [TWICE_BITS-1:0] ten_dly [SHIFT_DEPTH];
		logic [TWICE_BITS-1:0] kij_dly [SHIFT_DEPTH];
		logic [TWICE_BITS-1:0] wide_dly [SHIFT_DEPTH];
		bit                    ten_dly_ok [SHIFT_DEPTH];
		bit                    kij_dly_ok [SHIFT_DEPTH];
		bit                    wide_dly_ok [SHIFT_DEPTH];
		int unsigned           bar_count;
		logic [HIST_AW-1:0]    hist_slot;
		logic [SHIFT_AW-1:0]   dly_slot;
		logic [TENKAN_BITS-1:0] tenkan_reg;
		logic [KIJUN_BITS-1:0]  kijun_reg;
		ichi_out_t             due_lines [$];
		int unsigned           mismatches;
		int unsigned           lines_checked;

		function new();
			bar_count = 0;
			hist_slot = '0;
			dly_slot = '0;
			tenkan_reg = TENKAN_DEFAULT;
			kijun_reg = KIJUN_DEFAULT;
			mismatches = 0;
			lines_checked = 0;
		endfunction

		function void set_period(logic sel, logic [DATA_BITS-1:0] data);
			if (sel == REG_TENKAN) begin
				tenkan_reg = data[TENKAN_BITS-1:0];
			end else begin
				kijun_reg = data[KIJUN_BITS-1:0];
			end
		endfunction

		// zero falls back to the default, oversize saturates
		function int tenkan_len();
			int t;
			t = (tenkan_reg == 0) ? int'(TENKAN_DEFAULT) : int'(tenkan_reg);
			if (t > HIST_DEPTH) t = HIST_DEPTH;
			return t;
		endfunction

		function int kijun_len();
			int k, lim;
			lim = (SHIFT_DEPTH < HIST_DEPTH / 2) ? SHIFT_DEPTH : HIST_DEPTH / 2;
			k = (kijun_reg == 0) ? int'(KIJUN_DEFAULT) : int'(kijun_reg);
			if (k > lim) k = lim;
			return k;
		endfunction

		// highest high plus lowest low over the newest n bars, newest at hist_slot
		function logic [TWICE_BITS-1:0] donchian_sum(int n);
			logic [PRICE_BITS-1:0] hi, lo;
			logic [HIST_AW-1:0] s;
			hi = '0;
			lo = '1;
			for (int m = 0; m < n; m++) begin
				s = hist_slot - HIST_AW'(m);
				if (high_hist[s] > hi) hi = high_hist[s];
				if (low_hist[s] < lo) lo = low_hist[s];
			end
			return {1'b0, hi} + {1'b0, lo};
		endfunction

		function void take_bar(ichi_in_t bar);
			int t, k;
			logic [SHIFT_AW-1:0] rs;
			ichi_out_t want;
			t = tenkan_len();
			k = kijun_len();
			want = '0;
			if (bar.first_bar) bar_count = 0;
			high_hist[hist_slot] = bar.high_price;
			low_hist[hist_slot] = bar.low_price;
			if (bar_count < 65535) bar_count++;

			want.tenkan_valid = (bar_count >= t);
			want.kijun_valid = (bar_count >= k);
			if (want.tenkan_valid) want.tenkan_twice = donchian_sum(t);
			if (want.kijun_valid) want.kijun_twice = donchian_sum(k);

			// k bars back in the displacement store; k at full depth wraps onto this slot
			rs = dly_slot - SHIFT_AW'(k);
			want.lagging_close = bar.close_price;
			want.lagging_valid = (bar_count > k);
			if (want.lagging_valid) begin
				want.lead_mid_valid = ten_dly_ok[rs] && kij_dly_ok[rs];
				if (want.lead_mid_valid) begin
					want.lead_mid_quad = {1'b0, ten_dly[rs]} + {1'b0, kij_dly[rs]};
				end
				want.lead_wide_valid = wide_dly_ok[rs];
				if (want.lead_wide_valid) want.lead_wide_twice = wide_dly[rs];
			end

			ten_dly[dly_slot] = want.tenkan_twice;
			kij_dly[dly_slot] = want.kijun_twice;
			ten_dly_ok[dly_slot] = want.tenkan_valid;
			kij_dly_ok[dly_slot] = want.kijun_valid;
			wide_dly_ok[dly_slot] = (bar_count >= 2 * k);
			wide_dly[dly_slot] = wide_dly_ok[dly_slot] ? donchian_sum(2 * k) : '0;

			hist_slot++;
			dly_slot++;
			due_lines.push_back(want);
		endfunction

		function void check_field(string name, logic [QUAD_BITS-1:0] want,
				logic [QUAD_BITS-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_lines(ichi_out_t got);
			ichi_out_t want;
			if (due_lines.size() == 0) begin
				$error("line word arrived with no bar outstanding");
				mismatches++;
				return;
			end
			want = due_lines.pop_front();
			lines_checked++;
			check_field("tenkan_twice", want.tenkan_twice, got.tenkan_twice);
			check_field("tenkan_valid", want.tenkan_valid, got.tenkan_valid);
			check_field("kijun_twice", want.kijun_twice, got.kijun_twice);
			check_field("kijun_valid", want.kijun_valid, got.kijun_valid);
			check_field("lead_mid_quad", want.lead_mid_quad, got.lead_mid_quad);
			check_field("lead_mid_valid", want.lead_mid_valid, got.lead_mid_valid);
			check_field("lead_wide_twice", want.lead_wide_twice, got.lead_wide_twice);
			check_field("lead_wide_valid", want.lead_wide_valid, got.lead_wide_valid);
			check_field("lagging_close", want.lagging_close, got.lagging_close);
			check_field("lagging_valid", want.lagging_valid, got.lagging_valid);
		endfunction
	endclass

endpackage

FILE: bench/tb.sv
// Bench top for ichimoku_cloud_lines: drives bars and APB period writes, checks
// every line word against the predictor in cloud_check_pkg. Depends on ichi_pkg.
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ichi_pkg::*;
	import cloud_check_pkg::*;

	// limit for the whole run, set well above the slowest honest run
	localparam int unsigned LIMIT_CYCLES = 3_000_000;
	localparam int unsigned DRAIN_CYCLES = 200;    // > one full scan of the widest window
	localparam int unsigned PHASE_BARS   = 125;
	localparam int unsigned PHASES       = 14;
	localparam int unsigned HOLD_CYCLES  = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	ichi_in_t              in_word = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	ichi_out_t             out_word;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_BITS-1:0]  paddr = '0;
	logic [DATA_BITS-1:0]  pwdata = '0;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	cloud_line_predictor   book;
	int unsigned           cycle_count = 0;
	int unsigned           bars_sent = 0;
	int unsigned           settings_used = 0;
	int unsigned           reg_errors = 0;
	int unsigned           holds_done = 0;
	bit                    gaps_on = 1'b1;   // random idling on both sides
	bit                    hold_req = 1'b0;  // asks the receiver for one long hold-off
	logic [PRICE_BITS-1:0] walk_level = 32'd1_000_000;

	ichimoku_cloud_lines #(
		.MAX_WINDOW(HIST_DEPTH),
		.MAX_SHIFT(SHIFT_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic ichi_in_t mk_bar(logic [PRICE_BITS-1:0] h, logic [PRICE_BITS-1:0] l,
			logic [PRICE_BITS-1:0] c, logic f);
		ichi_in_t b;
		b.high_price = h;
		b.low_price = l;
		b.close_price = c;
		b.first_bar = f;
		return b;
	endfunction

	// a price at the ends of the range, a fully random one, or a single set bit
	function automatic logic [PRICE_BITS-1:0] edge_price();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return $urandom();
			default: return 32'd1 << $urandom_range(0, PRICE_BITS - 1);
		endcase
	endfunction

	// Mostly a random walk with a sane high/low band round it; some bars are
	// fully random (so high below low turns up) and some sit on the extremes.
	function automatic ichi_in_t rand_bar();
		ichi_in_t b;
		int unsigned up, dn;
		b.first_bar = ($urandom_range(0, 99) == 0);
		case ($urandom_range(0, 9))
			0: begin
				b.high_price = $urandom();
				b.low_price = $urandom();
				b.close_price = $urandom();
			end
			1: begin
				b.high_price = edge_price();
				b.low_price = edge_price();
				b.close_price = edge_price();
			end
			default: begin
				up = $urandom_range(0, 4096);
				dn = $urandom_range(0, 4096);
				walk_level = walk_level + $urandom_range(0, 2000) - 1000;
				b.high_price = walk_level + up;
				b.low_price = walk_level - dn;
				b.close_price = b.low_price + $urandom_range(0, up + dn);
			end
		endcase
		return b;
	endfunction

	// Offer one bar and wait until the block takes it. valid stays high straight
	// into the next bar when no gap is drawn, so it is never dropped and raised
	// within one step.
	task automatic send_bar(input ichi_in_t bar);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_word <= bar;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		book.take_bar(bar);
		bars_sent++;
	endtask

	// stop offering, then wait for every outstanding word to come back
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (book.due_lines.size() != 0) @(posedge clk);
	endtask

	// APB write (setup + access) then a read back of the same register.
	// Upper pwdata bits carry noise; only the register's own width is kept.
	task automatic reg_access(input logic sel, input logic [DATA_BITS-1:0] data);
		logic [DATA_BITS-1:0] keep;
		keep = (sel == REG_TENKAN) ? DATA_BITS'(data[TENKAN_BITS-1:0])
			: DATA_BITS'(data[KIJUN_BITS-1:0]);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_period(sel, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== keep) begin
			$error("prdata mismatch at 0x%0h: expected 0x%0h, got 0x%0h", {sel, 2'b00}, keep,
				prdata);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// periods only change with nothing in flight
	task automatic apply_periods(input logic [TENKAN_BITS-1:0] ten,
			input logic [KIJUN_BITS-1:0] kij);
		wait_quiet();
		reg_access(REG_TENKAN, ($urandom() & ~32'hFF) | DATA_BITS'(ten));
		reg_access(REG_KIJUN, ($urandom() & ~32'h7F) | DATA_BITS'(kij));
		settings_used++;
	endtask

	// receiver: random stall before each word, one long hold-off on request
	initial begin
		int unsigned wait_n;
		wait (arst_n === 1'b1);
		forever begin
			wait_n = gaps_on ? $urandom_range(0, 8) : 0;
			if (hold_req) begin
				wait_n = HOLD_CYCLES;
				hold_req = 1'b0;
				holds_done++;
			end
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			book.check_lines(out_word);
		end
	end

	initial begin
		logic [TENKAN_BITS-1:0] ten;
		logic [KIJUN_BITS-1:0] kij;
		book = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: short windows (tenkan 3, kijun 2, wide 4) so every line goes
		// valid within a few bars. Price extremes, high below low, an all-ones run
		// that drives the leading middle line to four times the top price, and
		// restarts both mid-series and back to back.
		apply_periods(8'd3, 7'd2);
		send_bar(mk_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
		send_bar(mk_bar(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
		send_bar(mk_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0));
		send_bar(mk_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
		send_bar(mk_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0));
		send_bar(mk_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
		repeat (6) send_bar(mk_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		send_bar(mk_bar(32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 1'b1));
		send_bar(mk_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
		send_bar(mk_bar(32'd10, 32'd5, 32'd7, 1'b0));
		send_bar(mk_bar(32'd12, 32'd3, 32'd9, 1'b0));
		send_bar(mk_bar(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0));
		send_bar(mk_bar(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0));
		send_bar(mk_bar(32'd100, 32'd200, 32'd150, 1'b0));

		// Random phases. The first six pin the corners: zero periods (defaults 9
		// and 26), oversize periods that saturate, both at the top, both at one,
		// and the two mixed corners. The rest lean to short windows.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_periods(8'd0, 7'd0);
				1: apply_periods(8'd255, 7'd127);
				2: apply_periods(8'd128, 7'd64);
				3: apply_periods(8'd1, 7'd1);
				4: apply_periods(8'd128, 7'd1);
				5: apply_periods(8'd1, 7'd64);
				default: begin
					ten = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
						: $urandom_range(1, 16);
					kij = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(1, 12);
					apply_periods(ten, kij);
				end
			endcase
			for (int i = 0; i < PHASE_BARS; i++) begin
				// fastest setting: a long receiver hold-off backs the block up
				if (ph == 3 && i == 40) hold_req = 1'b1;
				send_bar(rand_bar());
			end
		end

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d line words from %0d bars over %0d period settings, %0d long hold-off(s).",
			book.lines_checked, bars_sent, settings_used, holds_done);
		$display("Covered corner and saturating periods, restarts, price extremes and back-pressure.");
		if (book.mismatches == 0 && reg_errors == 0 && book.due_lines.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/ichi_pkg.sv
rtl/core/ichi_ram.sv
rtl/core/ichimoku_cloud_lines.sv
bench/cloud_check_pkg.sv
bench/tb.sv
